// ===== rtl/rrp_pkg.sv =====
// Shared types and constants for the row record parser.
// Depends on nothing; every other file in rtl imports it.
package rrp_pkg;

	localparam int MAX_COLUMNS = 64;

	localparam logic [7:0] TAG_INTEGER = 8'd1;
	localparam logic [7:0] TAG_TEXT    = 8'd2;

	localparam logic [7:0] CFG_COLUMN_COUNT = 8'd0;
	localparam logic [7:0] CFG_TEXT_MASK    = 8'd1;

	localparam int RES_FIFO_DEPTH = 4;
	localparam int RES_PTR_W      = 2;
	localparam int RES_CNT_W      = 3;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_TAG    = 3'd1,
		PH_INT    = 3'd2,
		PH_TLEN   = 3'd3,
		PH_TEXT   = 3'd4,
		PH_DONE   = 3'd5
	} rrp_phase_t;

	typedef enum logic [1:0] {
		KIND_INT        = 2'd0,
		KIND_TEXT_START = 2'd1,
		KIND_TEXT_BYTE  = 2'd2,
		KIND_ROW_END    = 2'd3
	} rrp_kind_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_TRUNC  = 2'd1,
		ST_SCHEMA = 2'd2,
		ST_TRAIL  = 2'd3
	} rrp_status_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       final_byte;
	} rrp_in_t;

	typedef struct packed {
		rrp_kind_t          result_kind;
		logic [5:0]         column_index;
		logic signed [63:0] payload_value;
		rrp_status_t        row_status;
		logic               run_last;
	} rrp_out_t;

	typedef struct packed {
		logic first_valid;
		logic second_valid;
	} rrp_push_t;

endpackage

// ===== rtl/rrp_parser.sv =====
// Row parse state machine and schema registers.
// Turns one accepted byte into up to two results in the same cycle.
// Depends on rrp_pkg.
module rrp_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_fire,
	input  logic [7:0]        cfg_index,
	input  logic [63:0]       cfg_data,
	input  logic              in_fire,
	input  rrp_pkg::rrp_in_t  in_data,
	output rrp_pkg::rrp_push_t push,
	output rrp_pkg::rrp_out_t first_res,
	output rrp_pkg::rrp_out_t second_res
);
	import rrp_pkg::*;

	logic [6:0]  schema_count_q;
	logic [63:0] schema_mask_q;

	rrp_phase_t  phase_q, phase_d;
	logic [3:0]  fbc_q, fbc_d;
	logic [6:0]  col_q, col_d;
	logic [63:0] asm_q, asm_d;
	logic [31:0] trem_q, trem_d;
	rrp_status_t err_q, err_d;
	logic        disc_q, disc_d;

	logic        data_valid;
	rrp_kind_t   data_kind;
	logic [63:0] data_value;
	rrp_status_t end_status;
	logic [6:0]  col_inc;
	logic        want_text;
	logic [31:0] trem_dec;
	logic [7:0]  b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			schema_count_q <= '0;
			schema_mask_q  <= '0;
		end else if (cfg_fire) begin
			if (cfg_index == CFG_COLUMN_COUNT) begin
				schema_count_q <= cfg_data[6:0];
			end else if (cfg_index == CFG_TEXT_MASK) begin
				schema_mask_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			fbc_q   <= '0;
			col_q   <= '0;
			trem_q  <= '0;
			err_q   <= ST_OK;
			disc_q  <= 1'b0;
		end else if (in_fire) begin
			phase_q <= phase_d;
			fbc_q   <= fbc_d;
			col_q   <= col_d;
			trem_q  <= trem_d;
			err_q   <= err_d;
			disc_q  <= disc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			asm_q <= asm_d;
		end
	end

	always_comb begin
		b          = in_data.payload_byte;
		phase_d    = phase_q;
		fbc_d      = fbc_q;
		col_d      = col_q;
		asm_d      = asm_q;
		trem_d     = trem_q;
		err_d      = err_q;
		disc_d     = disc_q;
		data_valid = 1'b0;
		data_kind  = KIND_INT;
		data_value = '0;
		col_inc    = col_q + 7'd1;
		want_text  = schema_mask_q[col_q[5:0]];
		trem_dec   = trem_q - 32'd1;
		end_status = ST_OK;

		if (!disc_q) begin
			unique case (phase_q)
				PH_HEADER: begin
					if (fbc_q[0]) begin
						fbc_d = '0;
						if (schema_count_q > 7'(MAX_COLUMNS) ||
						    {b, asm_q[7:0]} != {9'd0, schema_count_q}) begin
							err_d  = ST_SCHEMA;
							disc_d = 1'b1;
						end else begin
							col_d   = '0;
							phase_d = (schema_count_q == 7'd0) ? PH_DONE : PH_TAG;
						end
					end else begin
						asm_d[7:0] = b;
						fbc_d      = 4'd1;
					end
				end
				PH_TAG: begin
					if (b != (want_text ? TAG_TEXT : TAG_INTEGER)) begin
						err_d  = ST_SCHEMA;
						disc_d = 1'b1;
					end else begin
						phase_d = want_text ? PH_TLEN : PH_INT;
						fbc_d   = '0;
					end
				end
				PH_INT: begin
					asm_d[8*fbc_q[2:0] +: 8] = b;
					fbc_d = fbc_q + 4'd1;
					if (fbc_q[2:0] == 3'd7) begin
						data_valid = 1'b1;
						data_kind  = KIND_INT;
						data_value = {b, asm_q[55:0]};
						fbc_d      = '0;
						col_d      = col_inc;
						phase_d    = ({1'b0, col_inc} >= {1'b0, schema_count_q}) ?
							PH_DONE : PH_TAG;
					end
				end
				PH_TLEN: begin
					asm_d[8*fbc_q[1:0] +: 8] = b;
					fbc_d = fbc_q + 4'd1;
					if (fbc_q[1:0] == 2'd3) begin
						data_valid = 1'b1;
						data_kind  = KIND_TEXT_START;
						data_value = {32'd0, b, asm_q[23:0]};
						trem_d     = {b, asm_q[23:0]};
						fbc_d      = '0;
						if ({b, asm_q[23:0]} == 32'd0) begin
							col_d   = col_inc;
							phase_d = (col_inc >= schema_count_q) ? PH_DONE : PH_TAG;
						end else begin
							phase_d = PH_TEXT;
						end
					end
				end
				PH_TEXT: begin
					data_valid = 1'b1;
					data_kind  = KIND_TEXT_BYTE;
					data_value = {56'd0, b};
					trem_d     = trem_dec;
					if (trem_dec == 32'd0) begin
						col_d   = col_inc;
						phase_d = (col_inc >= schema_count_q) ? PH_DONE : PH_TAG;
					end
				end
				default: begin
					err_d  = ST_TRAIL;
					disc_d = 1'b1;
				end
			endcase
		end

		if (disc_d) begin
			end_status = err_d;
		end else if (phase_d == PH_DONE) begin
			end_status = ST_OK;
		end else begin
			end_status = ST_TRUNC;
		end

		if (in_data.final_byte) begin
			phase_d = PH_HEADER;
			fbc_d   = '0;
			col_d   = '0;
			trem_d  = '0;
			err_d   = ST_OK;
			disc_d  = 1'b0;
		end
	end

	rrp_out_t data_res, end_res;

	always_comb begin
		data_res.result_kind   = data_kind;
		data_res.column_index  = col_q[5:0];
		data_res.payload_value = data_value;
		data_res.row_status    = ST_OK;
		data_res.run_last      = !in_data.final_byte;

		end_res.result_kind   = KIND_ROW_END;
		end_res.column_index  = '0;
		end_res.payload_value = '0;
		end_res.row_status    = end_status;
		end_res.run_last      = 1'b1;

		push.first_valid  = in_fire && (data_valid || in_data.final_byte);
		push.second_valid = in_fire && data_valid && in_data.final_byte;
		first_res         = data_valid ? data_res : end_res;
		second_res        = end_res;
	end

endmodule

// ===== rtl/rrp_result_fifo.sv =====
// Result queue: takes up to two results a cycle, hands out one.
// Depends on rrp_pkg.
module rrp_result_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  rrp_pkg::rrp_push_t push,
	input  rrp_pkg::rrp_out_t  first_res,
	input  rrp_pkg::rrp_out_t  second_res,
	output logic               room,
	output logic               out_valid,
	input  logic               out_ready,
	output rrp_pkg::rrp_out_t  out_data
);
	import rrp_pkg::*;

	rrp_out_t               mem_q [RES_FIFO_DEPTH];
	logic [RES_PTR_W-1:0]   wr_q, rd_q;
	logic [RES_CNT_W-1:0]   cnt_q;
	logic                   pop;
	logic [RES_PTR_W-1:0]   wr_next;

	assign pop       = out_valid && out_ready;
	assign out_valid = cnt_q != '0;
	assign out_data  = mem_q[rd_q];
	assign room      = cnt_q <= RES_CNT_W'(RES_FIFO_DEPTH - 2);
	assign wr_next   = wr_q + RES_PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.first_valid) begin
			mem_q[wr_q] <= first_res;
		end
		if (push.second_valid) begin
			mem_q[wr_next] <= second_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + RES_PTR_W'(push.first_valid) + RES_PTR_W'(push.second_valid);
			rd_q  <= rd_q + RES_PTR_W'(pop);
			cnt_q <= cnt_q + RES_CNT_W'(push.first_valid) + RES_CNT_W'(push.second_valid)
				- RES_CNT_W'(pop);
		end
	end

endmodule

// ===== rtl/row_record_parser_top.sv =====
// A result enters the registered result queue when its byte is accepted and is offered once earlier results are taken.
// Throughput: one byte per cycle while results are taken; a byte that yields
// two results (a value and the row end) hands them out one after the other.
// Input ready is set by free space for two entries in the 4-entry result queue.
// Reset clears parse state, schema registers and the queue; no clearing pass.
// Depends on rrp_pkg, rrp_parser, rrp_result_fifo.
module row_record_parser_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [7:0]        cfg_index,
	input  logic [63:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  rrp_pkg::rrp_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output rrp_pkg::rrp_out_t out_data
);
	import rrp_pkg::*;

	rrp_push_t push;
	rrp_out_t  first_res, second_res;
	logic      room;

	assign cfg_ready = 1'b1;
	assign in_ready  = room;

	rrp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_fire   (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_fire    (in_valid && in_ready),
		.in_data    (in_data),
		.push       (push),
		.first_res  (first_res),
		.second_res (second_res)
	);

	rrp_result_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.first_res  (first_res),
		.second_res (second_res),
		.room       (room),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

// ===== rtl/rrp_checker.sv =====
// Port-level checks for row_record_parser_top, bound to the top level.
// Depends on rrp_pkg.
module rrp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input rrp_pkg::rrp_out_t out_data
);
	import rrp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.result_kind == KIND_ROW_END |-> out_data.run_last)
		else $error("row end without run_last");

	a_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.result_kind == KIND_ROW_END |->
		out_data.column_index == 6'd0 && out_data.payload_value == 64'sd0)
		else $error("row end carries column or value");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.result_kind != KIND_ROW_END |->
		out_data.row_status == ST_OK)
		else $error("status on a non row end result");

	a_text_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.result_kind == KIND_TEXT_BYTE |->
		out_data.payload_value[63:8] == 56'd0)
		else $error("text byte wider than a byte");

endmodule

bind row_record_parser_top rrp_checker u_rrp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
